// ===== rtl/core/calendar_date_sequencer_core_assert.svh =====
// Assertion macros used by the checker file of the date sequencer.
// Each macro takes a label, an antecedent, a consequent and a message string.
`ifndef CALENDAR_DATE_SEQUENCER_CORE_ASSERT_SVH
`define CALENDAR_DATE_SEQUENCER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cds_pkg.sv =====
package cds_pkg;

    localparam int unsigned DayW   = 5;
    localparam int unsigned MonthW = 4;
    localparam int unsigned YearW  = 14;
    localparam int unsigned WdayW  = 3;
    localparam int unsigned KeyW   = YearW + MonthW + DayW;
    localparam int unsigned IdxW   = 15;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 14;
    localparam int unsigned OutDataW = 32;
    localparam int unsigned InDataW  = 8;

    localparam logic [YearW-1:0]  MaxYear    = YearW'(9999);
    localparam logic [MonthW-1:0] MaxMonth   = MonthW'(12);
    localparam logic [WdayW-1:0]  MaxWeekday = WdayW'(6);

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] CfgFirstDay   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgFirstMonth = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgFirstYear  = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgFinalDay   = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgFinalMonth = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgFinalYear  = 3'd5;

    // y / 100 for y below 2**14, by reciprocal multiplication (exact in this range).
    function automatic logic [7:0] div100(input logic [YearW-1:0] y);
        logic [26:0] prod;
        prod = 27'(y) * 27'(5243);
        return prod[26:19];
    endfunction

    // x mod 7 for x below 2**15, by reciprocal multiplication and back-subtraction.
    function automatic logic [WdayW-1:0] mod7(input logic [IdxW-1:0] x);
        logic [31:0]     prod;
        logic [12:0]     q;
        logic [IdxW-1:0] r;
        prod = 32'(x) * 32'(74899);
        q    = prod[31:19];
        r    = x - IdxW'(q) * IdxW'(7);
        return r[WdayW-1:0];
    endfunction

    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic [7:0]       q;
        logic [YearW-1:0] rem;
        q   = div100(y);
        rem = y - YearW'(q) * YearW'(100);
        return (y[1:0] == 2'b00) && ((rem != '0) || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // 23 * m / 9 for the twelve months.
    function automatic logic [4:0] month_term(input logic [MonthW-1:0] m);
        logic [4:0] t;
        case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd17;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd30;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/calendar_date_sequencer_core.sv =====
// Calendar date sequencer.
// Each transaction on the slave stream (i_s_*) is one tick. Bit 0 of i_s_tdata
// is restart: 1 reloads the configured first date before emitting. A tick
// that produces a result emits the current date and its weekday on the
// master stream (o_m_*) and advances by one day; o_m_tlast marks the final
// date. Ticks while idle, after the final date, or with a first date later
// than the final date give no transaction on the master side.
// The result is registered: it appears in the cycle after the tick. One tick
// is taken every cycle while o_s_tready is high; the date step and end compare
// are short logic between the state registers and the single output register,
// and the weekday is carried as a counter. o_s_tready follows the output
// register: while a result waits on a stalled receiver no tick is taken.
// Configuration writes (i_cfg_*) are always taken. The clamped first and
// final dates and the first weekday are derived in a four-stage pipeline, so
// o_s_tready stays low until the settle counter expires after a write or reset.
// Reset restores the register defaults (2000-01-01 to 2000-12-31), clears
// the output valid flag and leaves the sequencer idle until a restart.
module calendar_date_sequencer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Tick stream. tdata bit 0: restart; other bits are zero.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [cds_pkg::InDataW-1:0]        i_s_tdata,
    // Date stream. tdata from bit 0: out_day[4:0], out_month[8:5],
    // out_year[22:9], weekday[25:23], zero fill [31:26].
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [cds_pkg::OutDataW-1:0]       o_m_tdata,
    output logic                               o_m_tlast,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cds_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [cds_pkg::CfgDataW-1:0]       i_cfg_data
);

    localparam int unsigned DW = cds_pkg::DayW;
    localparam int unsigned MW = cds_pkg::MonthW;
    localparam int unsigned YW = cds_pkg::YearW;
    localparam int unsigned WW = cds_pkg::WdayW;
    localparam int unsigned KW = cds_pkg::KeyW;
    localparam int unsigned XW = cds_pkg::IdxW;

    // Configuration registers.
    logic [DW-1:0] r_first_day,  r_final_day;
    logic [MW-1:0] r_first_month, r_final_month;
    logic [YW-1:0] r_first_year,  r_final_year;

    // Settle counter for the derived-value pipeline.
    logic [2:0] r_settle;

    // Stage 1: clamped months and years, leap flags.
    logic [MW-1:0] r_s1_fm, r_s1_em;
    logic [YW-1:0] r_s1_fy, r_s1_ey;
    logic          r_s1_fleap, r_s1_eleap;
    // Stage 2: clamped days, date keys and weekday terms of the first date.
    logic [DW-1:0] r_fd;
    logic [MW-1:0] r_fm;
    logic [YW-1:0] r_fy;
    logic          r_fleap;
    logic [KW-1:0] r_first_key, r_final_key;
    logic [YW-1:0] r_w_yy, r_w_dd;
    logic [7:0]    r_w_q100;
    logic [4:0]    r_w_mterm;
    // Stage 3: weekday index sum and start check.
    logic [XW-1:0] r_w_idx;
    logic          r_first_ok;
    // Stage 4: weekday of the first date.
    logic [WW-1:0] r_fwday;

    // Sequencer state.
    logic [DW-1:0] r_cur_day;
    logic [MW-1:0] r_cur_month;
    logic [YW-1:0] r_cur_year;
    logic [WW-1:0] r_cur_wday;
    logic          r_active;

    // Output register.
    logic          r_out_valid;
    logic [DW-1:0] r_out_day;
    logic [MW-1:0] r_out_month;
    logic [YW-1:0] r_out_year;
    logic [WW-1:0] r_out_wday;
    logic          r_out_last;

    logic in_accept;
    logic cfg_accept;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid;
    assign o_s_tready  = (r_settle == 3'd0) && !i_cfg_valid && (!r_out_valid || i_m_tready);
    assign in_accept   = i_s_tvalid && o_s_tready;

    // Configuration writes and the settle counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_day   <= DW'(1);
            r_first_month <= MW'(1);
            r_first_year  <= YW'(2000);
            r_final_day   <= DW'(31);
            r_final_month <= MW'(12);
            r_final_year  <= YW'(2000);
            r_settle      <= 3'd4;
        end else begin
            if (cfg_accept) begin
                r_settle <= 3'd4;
                unique case (i_cfg_index)
                    cds_pkg::CfgFirstDay:   r_first_day   <= i_cfg_data[DW-1:0];
                    cds_pkg::CfgFirstMonth: r_first_month <= i_cfg_data[MW-1:0];
                    cds_pkg::CfgFirstYear:  r_first_year  <= i_cfg_data[YW-1:0];
                    cds_pkg::CfgFinalDay:   r_final_day   <= i_cfg_data[DW-1:0];
                    cds_pkg::CfgFinalMonth: r_final_month <= i_cfg_data[MW-1:0];
                    cds_pkg::CfgFinalYear:  r_final_year  <= i_cfg_data[YW-1:0];
                    default: ;
                endcase
            end else if (r_settle != 3'd0) begin
                r_settle <= r_settle - 3'd1;
            end
        end
    end

    // Derived-value pipeline.
    logic [MW-1:0] n_s1_fm, n_s1_em;
    logic [YW-1:0] n_s1_fy, n_s1_ey;
    logic [DW-1:0] n_fd, n_ed, fd_len, ed_len;
    logic [YW-1:0] n_w_yy, n_w_dd;

    always_comb begin
        n_s1_fm = (r_first_month == '0) ? MW'(1) :
                  (r_first_month > cds_pkg::MaxMonth) ? cds_pkg::MaxMonth : r_first_month;
        n_s1_em = (r_final_month == '0) ? MW'(1) :
                  (r_final_month > cds_pkg::MaxMonth) ? cds_pkg::MaxMonth : r_final_month;
        n_s1_fy = (r_first_year == '0) ? YW'(1) :
                  (r_first_year > cds_pkg::MaxYear) ? cds_pkg::MaxYear : r_first_year;
        n_s1_ey = (r_final_year == '0) ? YW'(1) :
                  (r_final_year > cds_pkg::MaxYear) ? cds_pkg::MaxYear : r_final_year;

        fd_len = cds_pkg::month_len(r_s1_fm, r_s1_fleap);
        ed_len = cds_pkg::month_len(r_s1_em, r_s1_eleap);
        n_fd = (r_first_day == '0) ? DW'(1) : (r_first_day > fd_len) ? fd_len : r_first_day;
        n_ed = (r_final_day == '0) ? DW'(1) : (r_final_day > ed_len) ? ed_len : r_final_day;

        // For January and February the year terms use the year before; later months subtract two.
        if (r_s1_fm < MW'(3)) begin
            n_w_yy = r_s1_fy - YW'(1);
            n_w_dd = YW'(n_fd) + r_s1_fy;
        end else begin
            n_w_yy = r_s1_fy;
            n_w_dd = YW'(n_fd) + r_s1_fy - YW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_fm    <= n_s1_fm;
        r_s1_em    <= n_s1_em;
        r_s1_fy    <= n_s1_fy;
        r_s1_ey    <= n_s1_ey;
        r_s1_fleap <= cds_pkg::is_leap(n_s1_fy);
        r_s1_eleap <= cds_pkg::is_leap(n_s1_ey);

        r_fd        <= n_fd;
        r_fm        <= r_s1_fm;
        r_fy        <= r_s1_fy;
        r_fleap     <= r_s1_fleap;
        r_first_key <= {r_s1_fy, r_s1_fm, n_fd};
        r_final_key <= {r_s1_ey, r_s1_em, n_ed};
        r_w_yy      <= n_w_yy;
        r_w_dd      <= n_w_dd;
        r_w_q100    <= cds_pkg::div100(n_w_yy);
        r_w_mterm   <= cds_pkg::month_term(r_s1_fm);

        r_w_idx    <= XW'(r_w_mterm) + XW'(r_w_dd) + XW'(4) + XW'(r_w_yy >> 2)
                      - XW'(r_w_q100) + XW'(r_w_q100 >> 2);
        r_first_ok <= (r_first_key <= r_final_key);

        r_fwday <= cds_pkg::mod7(r_w_idx);
    end

    // Per-tick step: pick the date, check it against the final date, advance.
    logic          tick_restart;
    logic [DW-1:0] sel_day;
    logic [MW-1:0] sel_month;
    logic [YW-1:0] sel_year;
    logic [WW-1:0] sel_wday;
    logic          sel_leap, sel_active;
    logic [KW-1:0] cur_key;
    logic [DW-1:0] sel_len;
    logic          emit, is_last;
    logic [DW-1:0] n_cur_day;
    logic [MW-1:0] n_cur_month;
    logic [YW-1:0] n_cur_year;
    logic [WW-1:0] n_cur_wday;
    logic          n_active;

    always_comb begin
        tick_restart = i_s_tdata[0];
        sel_day    = tick_restart ? r_fd      : r_cur_day;
        sel_month  = tick_restart ? r_fm      : r_cur_month;
        sel_year   = tick_restart ? r_fy      : r_cur_year;
        sel_wday   = tick_restart ? r_fwday   : r_cur_wday;
        sel_leap   = tick_restart ? r_fleap   : cds_pkg::is_leap(r_cur_year);
        sel_active = tick_restart ? r_first_ok : r_active;

        cur_key = {sel_year, sel_month, sel_day};
        sel_len = cds_pkg::month_len(sel_month, sel_leap);
        emit    = sel_active && (cur_key <= r_final_key);
        is_last = (cur_key == r_final_key);

        n_cur_day   = sel_day;
        n_cur_month = sel_month;
        n_cur_year  = sel_year;
        n_cur_wday  = (sel_wday == cds_pkg::MaxWeekday) ? '0 : sel_wday + WW'(1);
        n_active    = emit;

        if (!emit) begin
            n_cur_wday = sel_wday;
        end else if (is_last) begin
            n_cur_wday = sel_wday;
            n_active   = 1'b0;
        end else if (sel_day < sel_len) begin
            n_cur_day = sel_day + DW'(1);
        end else begin
            n_cur_day = DW'(1);
            if (sel_month < cds_pkg::MaxMonth) begin
                n_cur_month = sel_month + MW'(1);
            end else if (sel_year < cds_pkg::MaxYear) begin
                n_cur_month = MW'(1);
                n_cur_year  = sel_year + YW'(1);
            end else begin
                // Stepping past the last representable date ends the run.
                n_cur_month = MW'(1);
                n_cur_year  = YW'(1);
                n_active    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_day   <= DW'(1);
            r_cur_month <= MW'(1);
            r_cur_year  <= YW'(1);
            r_cur_wday  <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_cur_day   <= n_cur_day;
                r_cur_month <= n_cur_month;
                r_cur_year  <= n_cur_year;
                r_cur_wday  <= n_cur_wday;
                r_active    <= n_active;
                r_out_valid <= emit;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; loaded only on ticks that emit.
    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_out_day   <= sel_day;
            r_out_month <= sel_month;
            r_out_year  <= sel_year;
            r_out_wday  <= sel_wday;
            r_out_last  <= is_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_wday, r_out_year, r_out_month, r_out_day};
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/core/cds_checker.sv =====
`include "calendar_date_sequencer_core_assert.svh"

module cds_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [cds_pkg::OutDataW-1:0]   o_m_tdata,
    input logic                           o_m_tlast
);

    // A stalled result holds its valid and payload.
    `CDS_ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast),
        "result changed while stalled")

    // No tick is taken while a result waits on a stalled receiver.
    `CDS_ASSERT_NOW(a_no_tick_on_stall, o_m_tvalid && !i_m_tready, !o_s_tready,
        "tick taken while the output is stalled")

    // The weekday never exceeds Saturday.
    `CDS_ASSERT_NOW(a_weekday_range, o_m_tvalid,
        o_m_tdata[25:23] <= cds_pkg::MaxWeekday, "weekday out of range")

    // Emitted day and month are always valid calendar values.
    `CDS_ASSERT_NOW(a_date_range, o_m_tvalid,
        (o_m_tdata[4:0] != 5'd0) && (o_m_tdata[8:5] != 4'd0) &&
        (o_m_tdata[8:5] <= cds_pkg::MaxMonth), "day or month out of range")

endmodule

bind calendar_date_sequencer_core cds_checker u_cds_checker (.*);
